[sv/sktl_pkg.sv]
// Shared types and codes for the sorted key table.
// No dependencies; imported by sorted_key_table_lookup.
package sktl_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned ENTRY_W = KEY_W + VAL_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_LK_RD,
    S_LK_CMP,
    S_RESP
  } state_t;

endpackage

[sv/sorted_key_table_lookup.sv]
// Sorted key table: insertion-sorted key/value store with binary-search lookup.
// Depends on sktl_pkg and sktl_ram.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------
//  in_     | in  | in_tvalid / in_tready | tuser: opcode; tdata: key, value
//  out_    | out | out_tvalid/out_tready | tuser: found, status; tdata: result_value
//
// One item at a time; the table lives in one RAM with a registered read port,
// so each probe or shift is an address step followed by a compare/write step.
//   clear / opcode 3 / full insert : straight to the response
//   insert : a read, then a compare/write, per entry moved up and once more to place
//            the new entry, whose write at entry 0 needs no compare; moved = greater keys
//   lookup : address and compare per probe, a last address step when bounds cross,
//            probes at most ceil(log2(count+1))
// Synchronous active-low reset empties the table; RAM contents are not cleared.
// in_tready stays low while reset is held.
// A finished result waits in the output register; the next beat is taken
// meanwhile, and a later result holds in the sequencer until that register frees.
module sorted_key_table_lookup
  import sktl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] key, [47:32] value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] result_value
  output logic [2:0]  out_tuser   // [0] found, [2:1] status
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;     // occupied entries
  logic [AW-1:0]        pos_r, pos_nxt;     // insert hole position
  logic [CW-1:0]        lo_r, lo_nxt;       // search left bound (may reach count)
  logic [AW-1:0]        hi_r, hi_nxt;       // search right bound
  logic [AW-1:0]        mid_r, mid_nxt;     // probed entry
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [VAL_W-1:0]     res_value_r, res_value_nxt;
  status_t              res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [VAL_W-1:0]     out_value_r, out_value_nxt;
  status_t              out_status_r, out_status_nxt;

  // RAM port signals
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [ENTRY_W-1:0]   mem_rdata;

  // shared comparator: request key against the entry just read
  logic [KEY_W-1:0]     rd_key;
  logic                 key_lt;             // request key < stored key
  logic                 key_eq;
  logic [AW-1:0]        mid_calc;
  logic                 in_beat;
  logic                 out_free;

  sktl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_key   = mem_rdata[KEY_W-1:0];
  assign key_lt   = key_r < rd_key;
  assign key_eq   = key_r == rd_key;
  assign mid_calc = lo_r[AW-1:0] + ((hi_r - lo_r[AW-1:0]) >> 1);

  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_status_r, out_found_r};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = {val_r, key_r};
    mem_raddr      = pos_r - AW'(1);

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          key_nxt        = in_tdata[KEY_W-1:0];
          val_nxt        = in_tdata[KEY_W +: VAL_W];
          res_found_nxt  = 1'b0;
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
          case (op_t'(in_tuser))
            OP_INSERT: begin
              if (cnt_r == CW'(TABLE_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                pos_nxt   = cnt_r[AW-1:0];
                state_nxt = S_INS_RD;
              end
            end
            OP_LOOKUP: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_MISS;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = AW'(cnt_r - CW'(1));
                state_nxt = S_LK_RD;
              end
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              // unused opcode: no effect, plain ok
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        mem_we = 1'b1;
        if (key_lt) begin
          // shift the greater entry up into the hole
          mem_wdata = mem_rdata;
          pos_nxt   = pos_r - AW'(1);
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_LK_RD: begin
        mem_raddr = mid_calc;
        if (lo_r > CW'(hi_r)) begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_RESP;
        end else begin
          mid_nxt   = mid_calc;
          state_nxt = S_LK_CMP;
        end
      end

      S_LK_CMP: begin
        mem_raddr = mid_r;
        state_nxt = S_LK_RD;
        if (key_eq) begin
          res_found_nxt = 1'b1;
          res_value_nxt = mem_rdata[KEY_W +: VAL_W];
          state_nxt     = S_RESP;
        end else if (!key_lt) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else if (mid_r == '0) begin
          // right bound would go below zero
          res_status_nxt = ST_MISS;
          state_nxt      = S_RESP;
        end else begin
          hi_nxt = mid_r - AW'(1);
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // table never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // count only steps up by one or drops to zero on clear
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + CW'(1) || cnt_r == '0))
    else $error("entry count jumped");

  // a probe only ever lands on an occupied entry
  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LK_CMP) |-> (CW'(mid_r) < cnt_r))
    else $error("lookup probe beyond occupied entries");

  // a hit always carries ok status
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == ST_OK))
    else $error("found result with non-ok status");

  // the table is written only by the insert steps
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_INS_RD || state_r == S_INS_CMP))
    else $error("table write outside insert");

endmodule

[sv/sktl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sktl_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
